// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTC serial master.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RTC3W_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RTC3W_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rtc3w_pkg.sv =====
// ----------------------------------------------------------------------------
// rtc3w_pkg
// Types, codes and the BCD decode function of the three-wire RTC master.
// ----------------------------------------------------------------------------
package rtc3w_pkg;

  // Bytes read by one burst request.
  localparam int unsigned BURST_BYTES = 8;

  // Request codes.
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_BURST = 2'd3;

  // Register indexes of the clock device.
  localparam logic [2:0] IDX_SEC   = 3'd0;
  localparam logic [2:0] IDX_MIN   = 3'd1;
  localparam logic [2:0] IDX_HOUR  = 3'd2;
  localparam logic [2:0] IDX_DATE  = 3'd3;
  localparam logic [2:0] IDX_MONTH = 3'd4;
  localparam logic [2:0] IDX_WDAY  = 3'd5;
  localparam logic [2:0] IDX_YEAR  = 3'd6;
  localparam logic [2:0] IDX_WP    = 3'd7;

  localparam logic [11:0] YEAR_BASE = 12'd2000;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMD,
    PH_WDATA,
    PH_READ
  } phase_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] command;
    logic [7:0] write_data;
    logic       io_in;
  } rtc3w_in_t;

  typedef struct packed {
    logic        chip_enable;
    logic        serial_clock;
    logic        io_drive;
    logic        io_out;
    logic        byte_valid;
    logic [7:0]  raw_byte;
    logic [11:0] decoded_value;
    logic [2:0]  byte_index;
    logic        last_byte;
    logic        busy_res;
  } rtc3w_out_t;

  // Decode one register byte; tens digit width depends on the register.
  function automatic logic [11:0] bcd_decode(input logic [7:0] b, input logic [2:0] idx);
    logic [3:0]  tens;
    logic [11:0] tens_w;
    logic [11:0] res;
    tens = 4'd0;
    unique case (idx)
      IDX_SEC, IDX_MIN:   tens = {1'b0, b[6:4]};
      IDX_HOUR, IDX_DATE: tens = {2'b00, b[5:4]};
      IDX_MONTH:          tens = {3'b000, b[4]};
      IDX_YEAR:           tens = b[7:4];
      default:            tens = 4'd0;
    endcase
    tens_w = {8'd0, tens};
    res = {8'd0, b[3:0]} + (tens_w << 3) + (tens_w << 1);
    unique case (idx)
      IDX_WDAY: res = {9'd0, b[2:0]};
      IDX_YEAR: res = res + YEAR_BASE;
      IDX_WP:   res = {4'd0, b[7], 7'd0};
      default:  res = res;
    endcase
    return res;
  endfunction

endpackage

// ===== src/rtc3w_channels.sv =====
// ----------------------------------------------------------------------------
// rtc3w channels
// Valid/ready channels for tick requests and per-tick line results.
// ----------------------------------------------------------------------------
interface rtc3w_in_if import rtc3w_pkg::*; ();
  logic      valid;
  logic      ready;
  rtc3w_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rtc3w_out_if import rtc3w_pkg::*; ();
  logic       valid;
  logic       ready;
  rtc3w_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== src/three_wire_rtc_serial_master.sv =====
// Result timing: the result beat for a tick is registered and appears in the cycle after the tick beat is taken.
// Throughput: one tick beat per cycle; the output register stands between the
// channels, so a new tick is taken whenever the result register is empty or drained.
// Reset: asynchronous, active low; the master returns to idle with the bit,
// half-tick and byte counters cleared and no result pending.
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master
// Pin-level master for a three-wire RTC link: command byte, then one written
// byte, one read byte or a burst of read bytes, two ticks per bit, LSB first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_wire_rtc_serial_master import rtc3w_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  rtc3w_in_if.sink    in_i,
  rtc3w_out_if.source res_o
);

  // Transaction state.
  phase_e      phase_q, phase_d;
  logic [2:0]  bit_cnt_q, bit_cnt_d;
  logic        half_q, half_d;
  logic [2:0]  byte_cnt_q, byte_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  data_q, data_d;
  logic [1:0]  op_q, op_d;

  // Result register.
  logic        out_valid_q;
  rtc3w_out_t  out_q, out_d;

  logic        in_fire;
  logic        start;

  // Effective state for this tick: a request taken while idle starts here.
  phase_e      ph_eff;
  logic [2:0]  bit_eff;
  logic        half_eff;
  logic [2:0]  byte_eff;
  logic [1:0]  op_eff;
  logic        tx_bit;
  logic        burst;
  logic [2:0]  idx;
  logic        last;
  logic [7:0]  shift_base;

  // Take a tick whenever the result register is empty or being drained.
  assign in_i.ready  = !out_valid_q || res_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign res_o.valid = out_valid_q;
  assign res_o.payload = out_q;

  assign start = (phase_q == PH_IDLE) && (in_i.payload.op != OP_NONE);

  always_comb begin
    // Latch a new request only while idle; otherwise hold the stored one.
    cmd_d  = start ? in_i.payload.command    : cmd_q;
    data_d = start ? in_i.payload.write_data : data_q;
    op_d   = start ? in_i.payload.op         : op_q;

    ph_eff   = start ? PH_CMD : phase_q;
    bit_eff  = start ? 3'd0   : bit_cnt_q;
    half_eff = start ? 1'b0   : half_q;
    byte_eff = start ? 3'd0   : byte_cnt_q;
    op_eff   = op_d;

    phase_d    = ph_eff;
    bit_cnt_d  = bit_eff;
    half_d     = half_eff;
    byte_cnt_d = byte_eff;
    shift_d    = shift_q;

    burst      = (op_eff == OP_BURST);
    idx        = burst ? byte_eff : cmd_d[3:1];
    last       = !burst || ((4'({1'b0, byte_eff}) + 4'd1) >= 4'(BURST_BYTES));
    tx_bit     = (ph_eff == PH_CMD) ? cmd_d[bit_eff] : data_d[bit_eff];
    shift_base = (bit_eff == 3'd0) ? 8'd0 : shift_q;

    // Idle lines: CE and SCLK low, IO driven low.
    out_d = '0;
    out_d.io_drive = 1'b1;

    unique case (ph_eff)
      PH_CMD, PH_WDATA: begin
        out_d.chip_enable = 1'b1;
        out_d.busy_res    = 1'b1;
        if (!half_eff) begin
          // Rising SCLK: drive the data bit.
          out_d.serial_clock = 1'b1;
          out_d.io_out       = tx_bit;
          half_d             = 1'b1;
        end else begin
          // Falling SCLK: drop IO, advance to the next bit or byte, or to idle after the written byte.
          half_d = 1'b0;
          if (bit_eff == 3'd7) begin
            bit_cnt_d = 3'd0;
            if (ph_eff == PH_CMD) begin
              phase_d = (op_eff == OP_WRITE) ? PH_WDATA : PH_READ;
            end else begin
              phase_d = PH_IDLE;
            end
          end else begin
            bit_cnt_d = bit_eff + 3'd1;
          end
        end
      end
      PH_READ: begin
        out_d.chip_enable = 1'b1;
        out_d.busy_res    = 1'b1;
        out_d.io_drive    = 1'b0;
        if (!half_eff) begin
          // Rising SCLK: sample IO into the byte being assembled.
          out_d.serial_clock = 1'b1;
          shift_d = shift_base;
          shift_d[bit_eff] = shift_base[bit_eff] | in_i.payload.io_in;
          half_d = 1'b1;
        end else begin
          half_d = 1'b0;
          if (bit_eff == 3'd7) begin
            // Byte complete: present it with its decoded value.
            bit_cnt_d           = 3'd0;
            out_d.byte_valid    = 1'b1;
            out_d.raw_byte      = shift_q;
            out_d.byte_index    = idx;
            out_d.decoded_value = bcd_decode(shift_q, idx);
            out_d.last_byte     = last;
            if (last) begin
              phase_d = PH_IDLE;
            end else begin
              byte_cnt_d = byte_eff + 3'd1;
            end
          end else begin
            bit_cnt_d = bit_eff + 3'd1;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Control state: advance only on an accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_cnt_q  <= 3'd0;
      half_q     <= 1'b0;
      byte_cnt_q <= 3'd0;
      op_q       <= OP_NONE;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      half_q     <= half_d;
      byte_cnt_q <= byte_cnt_d;
      op_q       <= op_d;
    end
  end

  // Held bytes and the receive shifter carry data only.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= cmd_d;
      data_q  <= data_d;
      shift_q <= shift_d;
    end
  end

  // Result register: load on a taken tick, clear once the beat leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  `RTC3W_ASSERT(a_fire_loads_result, clk_i, rst_ni, in_fire |=> out_valid_q, "tick taken but no result beat pending")
  `RTC3W_ASSERT(a_byte_only_in_read, clk_i, rst_ni, (in_fire && out_d.byte_valid) |-> (phase_q == PH_READ), "byte completed outside a read phase")
  `RTC3W_ASSERT(a_sclk_high_sets_half, clk_i, rst_ni, (in_fire && out_d.serial_clock) |=> half_q, "rising SCLK tick did not move to the second half")
  `RTC3W_ASSERT_ALWAYS(a_idle_counters_clear, clk_i, (phase_q == PH_IDLE) |-> ((bit_cnt_q == 3'd0) && !half_q), "bit counter or half tick left set while idle")

endmodule
